@@ hw/rtl/argtok_pkg.sv @@
// argtok_pkg: shared types and constants of the argument tokenizer.
// Parser state codes, character codes and the per-byte result struct.
// No dependencies.
`default_nettype none

package argtok_pkg;

    localparam int STATE_W = 3;
    localparam int CNT_W   = 16;

    localparam logic [STATE_W-1:0] ST_OUT = 3'd0;
    localparam logic [STATE_W-1:0] ST_ARG = 3'd1;
    localparam logic [STATE_W-1:0] ST_QUO = 3'd2;
    localparam logic [STATE_W-1:0] ST_ESA = 3'd3;
    localparam logic [STATE_W-1:0] ST_ESQ = 3'd4;

    localparam logic [7:0] CHR_NUL   = 8'h00;
    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_QUOTE = 8'h22;
    localparam logic [7:0] CHR_BSL   = 8'h5C;

    localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [7:0]       out_char;
        logic             append_valid;
        logic             arg_start;
        logic             arg_end;
        logic             line_done;
        logic             parse_error;
        logic [CNT_W-1:0] arg_total;
    } step_t;

endpackage

`default_nettype wire

@@ hw/rtl/argtok_step.sv @@
// argtok_step: per-byte transition logic of the tokenizer (combinational).
// Computes next parser state, next count and the result fields.
// Depends on argtok_pkg.
`default_nettype none

module argtok_step import argtok_pkg::*; (
    input  wire logic [STATE_W-1:0] state,
    input  wire logic [CNT_W-1:0]   count,
    input  wire logic [7:0]         in_byte,
    output logic [STATE_W-1:0]      state_next,
    output logic [CNT_W-1:0]        count_next,
    output step_t                   result
);

    logic             blank;
    logic             is_bsl;
    logic             is_quo;
    logic             is_nul;
    logic [CNT_W-1:0] count_one;
    logic             app;
    logic             start;
    logic             fin;
    logic             done;
    logic             err;
    logic [STATE_W-1:0] st_n;
    logic [CNT_W-1:0] cnt_n;

    assign blank     = in_byte inside {CHR_SPACE, CHR_TAB};
    assign is_bsl    = (in_byte == CHR_BSL);
    assign is_quo    = (in_byte == CHR_QUOTE);
    assign is_nul    = (in_byte == CHR_NUL);
    assign count_one = (count != CNT_MAX) ? count + 16'd1 : count;

    always_comb begin
        app   = 1'b0;
        start = 1'b0;
        fin   = 1'b0;
        done  = 1'b0;
        err   = 1'b0;
        st_n  = state;
        cnt_n = count;
        case (state)
            ST_ARG: begin
                if (blank) begin
                    fin   = 1'b1;
                    cnt_n = count_one;
                    st_n  = ST_OUT;
                end else if (is_bsl) begin
                    st_n = ST_ESA;
                end else if (is_quo) begin
                    st_n = ST_QUO;
                end else if (is_nul) begin
                    fin   = 1'b1;
                    cnt_n = count_one;
                    done  = 1'b1;
                end else begin
                    app = 1'b1;
                end
            end
            ST_QUO: begin
                if (is_bsl) begin
                    st_n = ST_ESQ;
                end else if (is_quo) begin
                    st_n = ST_ARG;
                end else if (is_nul) begin
                    err = 1'b1;
                end else begin
                    app = 1'b1;
                end
            end
            ST_ESA: begin
                if (is_nul) begin
                    err = 1'b1;
                end else begin
                    app  = 1'b1;
                    st_n = ST_ARG;
                end
            end
            ST_ESQ: begin
                if (is_nul) begin
                    err = 1'b1;
                end else begin
                    app  = 1'b1;
                    st_n = ST_QUO;
                end
            end
            default: begin
                if (blank) begin
                    st_n = ST_OUT;
                end else if (is_bsl) begin
                    start = 1'b1;
                    st_n  = ST_ESA;
                end else if (is_quo) begin
                    start = 1'b1;
                    st_n  = ST_QUO;
                end else if (is_nul) begin
                    done = 1'b1;
                    st_n = ST_OUT;
                end else begin
                    start = 1'b1;
                    app   = 1'b1;
                    st_n  = ST_ARG;
                end
            end
        endcase

        result.out_char     = app ? in_byte : 8'h00;
        result.append_valid = app;
        result.arg_start    = start;
        result.arg_end      = fin;
        result.line_done    = done;
        result.parse_error  = err;
        result.arg_total    = err ? '0 : cnt_n;

        if (done || err) begin
            state_next = ST_OUT;
            count_next = '0;
        end else begin
            state_next = st_n;
            count_next = cnt_n;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/argument_tokenizer.sv @@
// argument_tokenizer: shell-style command line splitter, one byte per transaction.
// Top level: parser state registers, result register, handshakes.
// Depends on argtok_pkg and argtok_step.
//
//  channel | direction | payload                                   | handshake
//  s_      | in        | s_in_byte                                 | s_valid/s_ready
//  m_      | out       | m_out_char, m_append_valid, m_arg_start,  | m_valid/m_ready
//          |           | m_arg_end, m_line_done, m_parse_error,    |
//          |           | m_arg_total                               |
//
// One byte per cycle while s_ready is high; each result is registered and appears in the cycle after its byte is taken.
// The parser state and count update at each input transaction, so only
// back-pressure on the m_ channel holds the byte flow.
// s_ready is high whenever the result register is empty or is being drained.
// aresetn (synchronous) clears parser state, count and m_valid.
`default_nettype none

module argument_tokenizer import argtok_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_in_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_char,
    output logic            m_append_valid,
    output logic            m_arg_start,
    output logic            m_arg_end,
    output logic            m_line_done,
    output logic            m_parse_error,
    output logic [15:0]     m_arg_total
);

    logic [STATE_W-1:0] state_reg;
    logic [STATE_W-1:0] state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               m_valid_reg;
    step_t              result_reg;
    step_t              result_next;
    logic               s_take;

    argtok_step u_step (
        .state      (state_reg),
        .count      (count_reg),
        .in_byte    (s_in_byte),
        .state_next (state_next),
        .count_next (count_next),
        .result     (result_next)
    );

    assign s_ready = !m_valid_reg || m_ready;
    assign s_take  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_OUT;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_take) begin
                state_reg <= state_next;
                count_reg <= count_next;
            end
            if (s_ready) begin
                m_valid_reg <= s_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            result_reg <= result_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_char     = result_reg.out_char;
    assign m_append_valid = result_reg.append_valid;
    assign m_arg_start    = result_reg.arg_start;
    assign m_arg_end      = result_reg.arg_end;
    assign m_line_done    = result_reg.line_done;
    assign m_parse_error  = result_reg.parse_error;
    assign m_arg_total    = result_reg.arg_total;

    a_err_no_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && result_reg.parse_error |-> result_reg.arg_total == '0)
        else $error("parse error with nonzero count");

    a_done_xor_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(result_reg.line_done && result_reg.parse_error))
        else $error("done and error together");

    a_end_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && result_reg.arg_end |-> result_reg.arg_total != '0)
        else $error("argument end without count");

    a_start_not_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(result_reg.arg_start && result_reg.arg_end))
        else $error("argument start and end on one byte");

    a_line_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        s_take && (result_next.line_done || result_next.parse_error)
        |=> state_reg == ST_OUT && count_reg == '0)
        else $error("parser not cleared after end of line");

endmodule

`default_nettype wire
